[sv/lap_pkg.sv]
package lap_pkg;

  localparam int MAX_STAGES_DEF        = 24;
  localparam int REFRESH_INTERVAL_DEF  = 20;
  localparam int SHAPE_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_PCT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_DEPTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_WET      = 3'd5;

  // reciprocals scaled by 2^32, used with one correction step
  localparam logic signed [29:0] RECIP_255 = 30'sd16843009;
  localparam logic signed [29:0] RECIP_25  = 30'sd171798691;

  localparam longint Q28_ONE = 64'sd268435456;
  localparam longint PI_Q28  = 64'sd843314857;

  typedef enum logic [4:0] {
    S_FILL,
    S_IDLE,
    S_LFO_IDX,
    S_LFO_ROM,
    S_LFO_SD,
    S_LFO_DQ,
    S_LFO_DC,
    S_FB_MUL,
    S_FB_DQ,
    S_FB_DC,
    S_ST_RD,
    S_ST_M1,
    S_ST_S1,
    S_ST_S2,
    S_MIX_A,
    S_MIX_B,
    S_MIX_DQ,
    S_MIX_DC,
    S_DONE
  } lap_state_t;

  // shift and subtract quotient, only used while building the shape table
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    logic [64:0]     rem;
    longint unsigned quo;
    int              b;
    rem = '0;
    quo = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= 65'(den)) begin
        rem    = rem - 65'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic longint cos_q28(input longint th);
    longint th2;
    longint sum;
    longint term;
    longint n;
    longint p;
    longint d;
    th2  = (th * th) / Q28_ONE;
    sum  = Q28_ONE;
    term = Q28_ONE;
    for (n = 1; n <= 14; n++) begin
      p = -((term * th2) / Q28_ONE);
      d = (2 * n - 1) * (2 * n);
      // truncate toward zero
      if (p < 0) term = -longint'(udiv64(-p, d));
      else term = longint'(udiv64(p, d));
      sum += term;
    end
    return sum;
  endfunction

  function automatic longint unsigned exp_q28(input longint unsigned x);
    longint unsigned sum;
    longint unsigned term;
    longint unsigned n;
    sum  = Q28_ONE;
    term = Q28_ONE;
    for (n = 1; n <= 40 && term != 0; n++) begin
      term = udiv64((term * x) >> 28, n);
      sum += term;
    end
    return sum;
  endfunction

  // (exp(2(1+cos a)) - 1) / (e^4 - 1) in Q1.16, evaluated at elaboration
  function automatic logic [16:0] shape_entry(input int idx, input int depth);
    longint u;
    longint th;
    longint x;
    longint unsigned e;
    longint unsigned v;
    longint unsigned den;
    den = exp_q28(4 * Q28_ONE) - Q28_ONE;
    u = idx;
    if (2 * u > depth) u = depth - u;
    th = longint'(udiv64(2 * PI_Q28 * u, depth));
    x = 2 * (Q28_ONE + cos_q28(th));
    if (x < 0) x = 0;
    if (x > 4 * Q28_ONE) x = 4 * Q28_ONE;
    e = exp_q28(x);
    if (e > Q28_ONE) v = e - Q28_ONE;
    else v = 0;
    v = udiv64(v * 65536 + den / 2, den);
    if (v > 65536) v = 65536;
    return 17'(v);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7FFFFF;
    else if (v < -32'sd8388608) return 24'sh800000;
    else return 24'(v);
  endfunction

endpackage

[sv/lap_ram.sv]
module lap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

[sv/lfo_allpass_phaser.sv]
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tdata: in_sample[15:0]; tuser: first_of_block
// out_     out  out_tvalid / out_tready   tdata: out_sample[15:0]
// cfg_     in   cfg_wr_en                 cfg_index, cfg_wdata (no read-back)
//
// an item is accepted only in the idle step, so the next accept waits until the last
// item is done; the stage loop sets the pace: one shared multiplier and the stage
// memory port take each stage in use through S_ST_M1, S_ST_S1 and S_ST_S2.
// after reset the shape memory is loaded with in_tready low; config writes are
// taken during that sweep.
// the output register holds a result while the next item is accepted; if it is
// still full when that item finishes, the item waits in its last step.
module lfo_allpass_phaser
  import lap_pkg::*;
#(
  parameter int MAX_STAGES        = MAX_STAGES_DEF,
  parameter int REFRESH_INTERVAL  = REFRESH_INTERVAL_DEF,
  parameter int SHAPE_TABLE_DEPTH = SHAPE_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] in_sample
  input  logic                  in_tuser,   // [0] first_of_block
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [15:0] out_sample
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SIDX_W = $clog2(MAX_STAGES);
  localparam int SCNT_W = $clog2(MAX_STAGES + 1);
  localparam int CNTR_W = (REFRESH_INTERVAL > 1) ? $clog2(REFRESH_INTERVAL) : 1;
  localparam int IDX_W  = $clog2(SHAPE_TABLE_DEPTH);

  // configuration
  logic [31:0]       lfo_step_r;
  logic [31:0]       start_phase_r;
  logic signed [7:0] fb_pct_r;
  logic [7:0]        lfo_depth_r;
  logic [4:0]        stage_count_r;
  logic [7:0]        dry_wet_r;

  lap_state_t state_r, state_nxt;

  logic [IDX_W-1:0]       fill_r, fill_nxt;
  logic [31:0]            phase_r, phase_nxt;
  logic [CNTR_W-1:0]      cnt_r, cnt_nxt;
  logic [CNTR_W-1:0]      cnt_eff;
  logic [16:0]            gain_r, gain_nxt;
  logic signed [23:0]     fb_r, fb_nxt;
  logic [MAX_STAGES-1:0]  stage_vld_r, stage_vld_nxt;
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [15:0]            out_tdata_r, out_tdata_nxt;

  logic signed [15:0]     x_r, x_nxt;
  logic signed [23:0]     m_r, m_nxt;
  logic signed [23:0]     t_r, t_nxt;
  logic [SCNT_W-1:0]      j_r, j_nxt;
  logic signed [62:0]     prod_r;
  logic [31:0]            div_v_r, div_v_nxt;
  logic                   neg_r, neg_nxt;
  logic signed [32:0]     acc_r, acc_nxt;
  logic [15:0]            res_r, res_nxt;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [62:0] mul_p;

  // memories
  logic [16:0]       shape_rom [SHAPE_TABLE_DEPTH];
  logic              shape_we;
  logic [IDX_W-1:0]  shape_rd_addr;
  logic [16:0]       shape_rdata;
  logic              stage_we;
  logic [SIDX_W-1:0] stage_rd_addr;
  logic [23:0]       stage_rdata;

  // datapath helpers
  logic [4:0]         sc_even;
  logic [SCNT_W-1:0]  n_stages;
  logic [SCNT_W-1:0]  j_inc;
  logic [31:0]        q0;
  logic [31:0]        div_c;
  logic [31:0]        q_val;
  logic signed [62:0] gm_w;
  logic signed [31:0] gm;
  logic signed [23:0] ns_val;
  logic signed [23:0] t_val;
  logic signed [31:0] fb_p;
  logic [31:0]        fb_abs;
  logic signed [31:0] q_signed;
  logic signed [33:0] mix_sum;
  logic [33:0]        mix_abs;

  for (genvar gi = 0; gi < SHAPE_TABLE_DEPTH; gi++) begin : g_shape
    localparam logic [16:0] ENTRY = shape_entry(gi, SHAPE_TABLE_DEPTH);
    assign shape_rom[gi] = ENTRY;
  end

  lap_ram #(
    .WIDTH (17),
    .DEPTH (SHAPE_TABLE_DEPTH)
  ) u_shape_ram (
    .clk     (clk),
    .wr_en   (shape_we),
    .wr_addr (fill_r),
    .wr_data (shape_rom[fill_r]),
    .rd_addr (shape_rd_addr),
    .rd_data (shape_rdata)
  );

  lap_ram #(
    .WIDTH (24),
    .DEPTH (MAX_STAGES)
  ) u_stage_ram (
    .clk     (clk),
    .wr_en   (stage_we),
    .wr_addr (j_r[SIDX_W-1:0]),
    .wr_data (ns_val),
    .rd_addr (stage_rd_addr),
    .rd_data (stage_rdata)
  );

  assign mul_p = mul_a * mul_b;

  assign sc_even  = {stage_count_r[4:1], 1'b0};
  assign n_stages = (32'(sc_even) > 32'(MAX_STAGES)) ? SCNT_W'(MAX_STAGES & ~1)
                                                      : SCNT_W'(sc_even);
  assign j_inc    = j_r + SCNT_W'(1);

  assign shape_rd_addr = prod_r[32 +: IDX_W];

  // quotient estimate from the reciprocal product, then one correction
  assign q0    = {1'b0, prod_r[62:32]};
  assign div_c = (state_r == S_FB_DC) ? 32'd25 : 32'd255;
  assign q_val = (div_v_r >= (q0 + 32'd1) * div_c) ? q0 + 32'd1 : q0;
  assign q_signed = neg_r ? -signed'(q_val) : signed'(q_val);

  // g*v rounded: floor((p + 32768) / 65536)
  assign gm_w   = (prod_r + 63'sd32768) >>> 16;
  assign gm     = gm_w[31:0];
  assign ns_val = sat24(gm + 32'(m_r));
  assign t_val  = stage_vld_r[j_r[SIDX_W-1:0]] ? signed'(stage_rdata) : 24'sd0;

  assign fb_p   = signed'(prod_r[31:0]);
  assign fb_abs = fb_p[31] ? 32'(-fb_p) : 32'(fb_p);

  assign mix_sum = 34'(acc_r) + 34'(signed'(prod_r[32:0]));
  assign mix_abs = mix_sum[33] ? 34'(-mix_sum) : 34'(mix_sum);

  assign cnt_eff = in_tuser ? '0 : cnt_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    gain_nxt       = gain_r;
    fb_nxt         = fb_r;
    stage_vld_nxt  = stage_vld_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    x_nxt          = x_r;
    m_nxt          = m_r;
    t_nxt          = t_r;
    j_nxt          = j_r;
    div_v_nxt      = div_v_r;
    neg_nxt        = neg_r;
    acc_nxt        = acc_r;
    res_nxt        = res_r;
    mul_a          = '0;
    mul_b          = '0;
    shape_we       = 1'b0;
    stage_we       = 1'b0;
    stage_rd_addr  = j_r[SIDX_W-1:0];

    case (state_r)
      S_FILL: begin
        shape_we = 1'b1;
        fill_nxt = fill_r + IDX_W'(1);
        if (fill_r == IDX_W'(SHAPE_TABLE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          x_nxt = signed'(in_tdata);
          if (in_tuser) begin
            fb_nxt        = '0;
            gain_nxt      = '0;
            stage_vld_nxt = '0;
          end
          phase_nxt = (in_tuser ? start_phase_r : phase_r) + lfo_step_r;
          cnt_nxt   = (32'(cnt_eff) == REFRESH_INTERVAL - 1) ? '0 : cnt_eff + CNTR_W'(1);
          state_nxt = (cnt_eff == '0) ? S_LFO_IDX : S_FB_MUL;
        end
      end
      S_LFO_IDX: begin
        mul_a     = {1'b0, phase_r};
        mul_b     = 30'(SHAPE_TABLE_DEPTH);
        state_nxt = S_LFO_ROM;
      end
      S_LFO_ROM: begin
        // shape read address comes from the index product
        state_nxt = S_LFO_SD;
      end
      S_LFO_SD: begin
        mul_a     = 33'(shape_rdata);
        mul_b     = 30'(lfo_depth_r);
        state_nxt = S_LFO_DQ;
      end
      S_LFO_DQ: begin
        div_v_nxt = prod_r[31:0] + 32'd127;
        mul_a     = {1'b0, div_v_nxt};
        mul_b     = RECIP_255;
        state_nxt = S_LFO_DC;
      end
      S_LFO_DC: begin
        gain_nxt  = 17'd65536 - q_val[16:0];
        state_nxt = S_FB_MUL;
      end
      S_FB_MUL: begin
        mul_a     = 33'(fb_r);
        mul_b     = 30'(fb_pct_r);
        state_nxt = S_FB_DQ;
      end
      S_FB_DQ: begin
        // round(|p|/100) = floor(floor((|p|+50)/4)/25)
        neg_nxt   = fb_p[31];
        div_v_nxt = (fb_abs + 32'd50) >> 2;
        mul_a     = {1'b0, div_v_nxt};
        mul_b     = RECIP_25;
        state_nxt = S_FB_DC;
      end
      S_FB_DC: begin
        m_nxt     = sat24((32'(x_r) <<< 5) + q_signed);
        j_nxt     = '0;
        state_nxt = (n_stages == '0) ? S_MIX_A : S_ST_RD;
      end
      S_ST_RD: begin
        state_nxt = S_ST_M1;
      end
      S_ST_M1: begin
        t_nxt     = t_val;
        mul_a     = 33'(t_val);
        mul_b     = 30'(gain_r);
        state_nxt = S_ST_S1;
      end
      S_ST_S1: begin
        stage_we                           = 1'b1;
        stage_vld_nxt[j_r[SIDX_W-1:0]]     = 1'b1;
        mul_a                              = 33'(ns_val);
        mul_b                              = 30'(gain_r);
        state_nxt                          = S_ST_S2;
      end
      S_ST_S2: begin
        m_nxt         = sat24(32'(t_r) - gm);
        j_nxt         = j_inc;
        stage_rd_addr = j_inc[SIDX_W-1:0];
        state_nxt     = (j_inc == n_stages) ? S_MIX_A : S_ST_M1;
      end
      S_MIX_A: begin
        fb_nxt    = m_r;
        mul_a     = 33'(m_r);
        mul_b     = 30'(dry_wet_r);
        state_nxt = S_MIX_B;
      end
      S_MIX_B: begin
        acc_nxt   = prod_r[32:0];
        mul_a     = 33'(x_r) <<< 5;
        mul_b     = 30'(8'd255 - dry_wet_r);
        state_nxt = S_MIX_DQ;
      end
      S_MIX_DQ: begin
        // round(|N|/8160) = floor(floor((|N|+4080)/32)/255)
        neg_nxt   = mix_sum[33];
        div_v_nxt = 32'((mix_abs + 34'd4080) >> 5);
        mul_a     = {1'b0, div_v_nxt};
        mul_b     = RECIP_255;
        state_nxt = S_MIX_DC;
      end
      S_MIX_DC: begin
        if (q_signed > 32'sd32767) res_nxt = 16'h7FFF;
        else if (q_signed < -32'sd32768) res_nxt = 16'h8000;
        else res_nxt = q_signed[15:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_FILL;
      fill_r        <= '0;
      phase_r       <= '0;
      cnt_r         <= '0;
      gain_r        <= '0;
      fb_r          <= '0;
      stage_vld_r   <= '0;
      out_tvalid_r  <= 1'b0;
      lfo_step_r    <= '0;
      start_phase_r <= '0;
      fb_pct_r      <= '0;
      lfo_depth_r   <= '0;
      stage_count_r <= 5'd4;
      dry_wet_r     <= 8'd128;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      gain_r       <= gain_nxt;
      fb_r         <= fb_nxt;
      stage_vld_r  <= stage_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_LFO_STEP:     lfo_step_r    <= cfg_wdata;
          CFG_START_PHASE:  start_phase_r <= cfg_wdata;
          CFG_FEEDBACK_PCT: fb_pct_r      <= signed'(cfg_wdata[7:0]);
          CFG_LFO_DEPTH:    lfo_depth_r   <= cfg_wdata[7:0];
          CFG_STAGE_COUNT:  stage_count_r <= cfg_wdata[4:0];
          CFG_DRY_WET:      dry_wet_r     <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    x_r         <= x_nxt;
    m_r         <= m_nxt;
    t_r         <= t_nxt;
    j_r         <= j_nxt;
    prod_r      <= mul_p;
    div_v_r     <= div_v_nxt;
    neg_r       <= neg_nxt;
    acc_r       <= acc_nxt;
    res_r       <= res_nxt;
  end

  a_stage_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ST_M1) |-> (j_r < n_stages))
    else $error("stage index beyond stages in use");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready stayed high after an item was accepted");

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= 17'd65536)
    else $error("lfo gain above unity");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("output loaded outside the done step");

endmodule

[verif/lfo_allpass_phaser_test.sv]
module lfo_allpass_phaser_test;
  import lap_pkg::*;

  localparam int MAX_ST    = MAX_STAGES_DEF;
  localparam int REFRESH   = REFRESH_INTERVAL_DEF;
  localparam int TAB_DEPTH = SHAPE_TABLE_DEPTH_DEF;

  localparam longint UNIT_Q28      = 64'sd268435456;
  localparam longint HALF_TURN_Q28 = 64'sd843314857;
  localparam longint MIX_DIV       = 255 * 32;

  // indexes past the last register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 6000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_PHASES = 14;
  localparam int MAX_REPORTS   = 100;

  typedef struct {
    logic [31:0]       step;
    logic [31:0]       phase0;
    logic signed [7:0] fb;
    logic [7:0]        depth;
    logic [4:0]        stages;
    logic [7:0]        mix;
  } phaser_setting_t;

  class phaser_scoreboard;
    logic [16:0]        shape_rom [TAB_DEPTH];
    logic [31:0]        lfo_step;
    logic [31:0]        start_phase;
    logic signed [7:0]  fb_pct;
    logic [7:0]         lfo_depth;
    logic [7:0]         dry_wet;
    logic [4:0]         stage_cfg;
    logic signed [23:0] stage_mem [MAX_ST];
    logic signed [23:0] fb_value;
    logic [16:0]        lfo_gain;
    int unsigned        refresh_cnt;
    logic [31:0]        phase_acc;
    logic [15:0]        out_samples_due [$];
    int unsigned        mismatches;
    int unsigned        outputs_checked;

    function new();
      longint unsigned den;
      longint unsigned e;
      longint unsigned v;
      longint u;
      longint th;
      longint th2;
      longint arg;
      longint cs;
      longint term;
      int i;
      int k;
      den = exp_series(4 * UNIT_Q28) - UNIT_Q28;
      for (i = 0; i < TAB_DEPTH; i++) begin
        u = i;
        if (2 * u > TAB_DEPTH) u = TAB_DEPTH - u;
        th = (2 * HALF_TURN_Q28 * u) / TAB_DEPTH;
        // cosine on the folded angle, 14 series terms
        th2 = (th * th) / UNIT_Q28;
        cs = UNIT_Q28;
        term = UNIT_Q28;
        for (k = 1; k <= 14; k++) begin
          term = -((term * th2) / UNIT_Q28) / ((2 * k - 1) * (2 * k));
          cs += term;
        end
        arg = 2 * (UNIT_Q28 + cs);
        if (arg < 0) arg = 0;
        if (arg > 4 * UNIT_Q28) arg = 4 * UNIT_Q28;
        e = exp_series(arg);
        v = (e > UNIT_Q28) ? e - UNIT_Q28 : 0;
        v = (v * 65536 + den / 2) / den;
        if (v > 65536) v = 65536;
        shape_rom[i] = v[16:0];
      end
      lfo_step = '0;
      start_phase = '0;
      fb_pct = '0;
      lfo_depth = '0;
      stage_cfg = 5'd4;
      dry_wet = 8'd128;
      mismatches = 0;
      outputs_checked = 0;
      clear_block();
    endfunction

    function longint unsigned exp_series(longint unsigned x);
      longint unsigned acc;
      longint unsigned term;
      longint unsigned k;
      acc = UNIT_Q28;
      term = UNIT_Q28;
      for (k = 1; k <= 40 && term != 0; k++) begin
        term = ((term * x) >> 28) / k;
        acc += term;
      end
      return acc;
    endfunction

    function logic signed [23:0] clamp24(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return 24'(v);
    endfunction

    // nearest, ties away from zero
    function longint round_div(longint num, longint den);
      if (num >= 0) return (num + den / 2) / den;
      return -((-num + den / 2) / den);
    endfunction

    // gain times value in q1.16, rounded half up
    function longint gain_mul(logic [16:0] g, longint v);
      return (longint'(g) * v + 32768) >>> 16;
    endfunction

    function void clear_block();
      foreach (stage_mem[j]) stage_mem[j] = '0;
      fb_value = '0;
      lfo_gain = '0;
      refresh_cnt = 0;
      phase_acc = start_phase;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LFO_STEP:     lfo_step = val;
        CFG_START_PHASE:  start_phase = val;
        CFG_FEEDBACK_PCT: fb_pct = val[7:0];
        CFG_LFO_DEPTH:    lfo_depth = val[7:0];
        CFG_STAGE_COUNT:  stage_cfg = val[4:0];
        CFG_DRY_WET:      dry_wet = val[7:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [15:0] s, logic first);
      longint x;
      longint m;
      longint t;
      longint unsigned pos;
      logic signed [23:0] ns;
      int n;
      int j;
      x = longint'(s);
      if (first) clear_block();
      phase_acc = phase_acc + lfo_step;
      if (refresh_cnt == 0) begin
        pos = (64'(phase_acc) * TAB_DEPTH) >> 32;
        lfo_gain = 17'(65536 - (longint'(shape_rom[pos]) * longint'(lfo_depth) + 127) / 255);
      end
      refresh_cnt = (refresh_cnt + 1) % REFRESH;
      m = clamp24(x * 32 + round_div(longint'(fb_value) * longint'(fb_pct), 100));
      n = {stage_cfg[4:1], 1'b0};
      if (n > MAX_ST) n = MAX_ST & ~1;
      for (j = 0; j < n; j++) begin
        t = stage_mem[j];
        ns = clamp24(gain_mul(lfo_gain, t) + m);
        stage_mem[j] = ns;
        m = clamp24(t - gain_mul(lfo_gain, longint'(ns)));
      end
      fb_value = m[23:0];
      m = round_div(m * longint'(dry_wet) + x * 32 * (255 - longint'(dry_wet)), MIX_DIV);
      if (m > 32767) m = 32767;
      else if (m < -32768) m = -32768;
      out_samples_due.push_back(m[15:0]);
    endfunction

    function void check_output(logic signed [15:0] got);
      logic signed [15:0] want;
      outputs_checked++;
      if (out_samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $error("out_sample: expected none, actual %0d", got);
        return;
      end
      want = out_samples_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("out_sample: expected %0d, actual %0d", want, got);
      end
    endfunction

    function int pending();
      return out_samples_due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [15:0]           out_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  phaser_scoreboard sb;
  bit steady;
  bit hold_out;
  int samples_sent;
  int settings_applied;
  int quiet_cycles;

  lfo_allpass_phaser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("lfo_allpass_phaser verification failed");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // entered and left at a falling edge; valid stays high between items except in random idle gaps, off when steady
  task automatic send_item(input logic [15:0] s, input logic first);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tuser <= first;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s, first);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_outputs();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // narrow registers get random upper bits, which must be dropped
  task automatic load_setting(input phaser_setting_t st, input bit spare);
    write_cfg(CFG_LFO_STEP, st.step);
    write_cfg(CFG_START_PHASE, st.phase0);
    write_cfg(CFG_FEEDBACK_PCT, {24'($urandom()), st.fb});
    write_cfg(CFG_LFO_DEPTH, {24'($urandom()), st.depth});
    write_cfg(CFG_STAGE_COUNT, {27'($urandom()), st.stages});
    write_cfg(CFG_DRY_WET, {24'($urandom()), st.mix});
    if (spare) begin
      write_cfg(CFG_SPARE_A, $urandom());
      write_cfg(CFG_SPARE_B, $urandom());
    end
    cfg_wr_en <= 1'b0;
    settings_applied++;
  endtask

  function automatic phaser_setting_t pick_setting(int ph);
    phaser_setting_t st;
    if (ph == 0) begin
      st = '{32'd0, 32'd0, 8'sd127, 8'd0, 5'd0, 8'd255};
      return st;
    end
    if (ph == 1) begin
      st = '{32'd1, '1, -8'sd128, 8'd255, 5'd24, 8'd0};
      return st;
    end
    case ($urandom_range(3))
      0: st.step = '0;
      1: st.step = '1;
      2: st.step = 32'($urandom_range(1, 1 << 24));
      default: st.step = $urandom();
    endcase
    case ($urandom_range(3))
      0: st.phase0 = '0;
      1: st.phase0 = '1;
      default: st.phase0 = $urandom();
    endcase
    case ($urandom_range(3))
      0: st.fb = 8'($urandom());
      1: st.fb = $urandom_range(1) ? 8'sd100 : -8'sd100;
      2: st.fb = $urandom_range(1) ? 8'sd127 : -8'sd128;
      default: st.fb = 8'(int'($urandom_range(200)) - 100);
    endcase
    case ($urandom_range(2))
      0: st.depth = 8'd0;
      1: st.depth = 8'd255;
      default: st.depth = 8'($urandom());
    endcase
    st.stages = 5'($urandom_range(31));
    case ($urandom_range(3))
      0: st.mix = 8'd0;
      1: st.mix = 8'd255;
      2: st.mix = 8'd128;
      default: st.mix = 8'($urandom());
    endcase
    return st;
  endfunction

  function automatic logic [15:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) return 16'($urandom());
    if (pick < 70) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if (pick < 90) return 16'(int'($urandom_range(2048)) - 1024);
    return $urandom_range(1) ? 16'(32767 - $urandom_range(255)) : 16'(-32768 + $urandom_range(255));
  endfunction

  initial begin
    phaser_setting_t st;
    int ph;
    int k;
    int count;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    steady = 1'b0;
    hold_out = 1'b0;
    samples_sent = 0;
    settings_applied = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: four stages, half mix, no feedback, no modulation
    send_item(16'h7FFF, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h0000, 1'b1);

    // extremes: odd count past the top, feedback over 100%, full depth and wet
    wait_for_outputs();
    st = '{'1, 32'h8000_0000, 8'sd127, 8'd255, 5'd31, 8'd255};
    load_setting(st, 1'b1);
    send_item(16'h7FFF, 1'b1);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h7FFF, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h1234, 1'b1);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_outputs();
      load_setting(pick_setting(ph), ph % 4 == 0);
      steady = (ph == 3);
      if (ph == 6) hold_out = 1'b1;
      count = $urandom_range(90, 140);
      for (k = 0; k < count; k++) begin
        if (ph == 9 && k == count / 2) wait_for_outputs();
        send_item(random_sample(),
                  (k == 0) ? 1'($urandom_range(1)) : 1'($urandom_range(49) == 0));
      end
    end
    steady = 1'b0;

    wait_for_outputs();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run: %0d samples under %0d register settings, %0d outputs compared, %0d bad",
             samples_sent, settings_applied, sb.outputs_checked, sb.mismatches);
    $display("run: stage counts 0..31, feedback -128..127, full lfo depth, long output hold");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lfo_allpass_phaser verification clean");
    end else begin
      $display("lfo_allpass_phaser verification failed");
    end
    $finish;
  end

endmodule
